/* hdl/zone_intrusion_tracker_defines.svh */
// Assertion macros for the zone intrusion tracker.
`ifndef ZONE_INTRUSION_TRACKER_DEFINES_SVH
`define ZONE_INTRUSION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define ZIT_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);
`define ZIT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define ZIT_ASSERT_NOW(lbl, trig, cond, msg)
`define ZIT_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

/* hdl/zit_pkg.sv */
// Shared types, register indexes and helpers for the zone intrusion tracker.
package zit_pkg;

  localparam int COORD_W = 16;
  localparam int MASK_W  = 4;
  localparam int ID_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [MASK_W-1:0]     mask_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_ENABLE,
    REG_ZONE_RECT_0,
    REG_ZONE_RECT_1,
    REG_ZONE_RECT_2,
    REG_ZONE_RECT_3
  } cfg_reg_t;

  // Rectangle with corners already ordered, bounds inclusive.
  typedef struct packed {
    coord_t x_lo;
    coord_t y_lo;
    coord_t x_hi;
    coord_t y_hi;
  } rect_t;

  typedef rect_t [MASK_W-1:0] rect_arr_t;

  function automatic rect_t order_rect(input coord_t ax, input coord_t ay,
                                       input coord_t bx, input coord_t by,
                                       input coord_t keep);
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    rect_t  r;
    x1 = ax & keep;
    y1 = ay & keep;
    x2 = bx & keep;
    y2 = by & keep;
    r.x_lo = (x1 > x2) ? x2 : x1;
    r.x_hi = (x1 > x2) ? x1 : x2;
    r.y_lo = (y1 > y2) ? y2 : y1;
    r.y_hi = (y1 > y2) ? y1 : y2;
    return r;
  endfunction

endpackage

/* hdl/zone_intrusion_tracker.sv */
// Top level of the zone intrusion tracker.
// Takes one object box per clock while in_stall is low and returns one result per box. In the
// accept cycle the box corners are ordered and the object's membership entry is read from a
// one-port-read, one-port-write RAM; in stage 1 the box is tested against all zones in
// parallel, the entered/left/inside masks are formed, the entry is written back and the
// output register is loaded. A request that hits the entry written in the same cycle takes
// the new value from a forward register. A result left waiting stalls the input once the
// stage behind it is also full. Reset clears membership at once through one valid bit per
// entry; there is no clearing pass. Object ids are taken modulo MAX_OBJECTS. The user must
// write zone registers only while the block is idle; the block itself does not enforce it.
`include "zone_intrusion_tracker_defines.svh"

module zone_intrusion_tracker #(
  parameter int NUM_ZONES   = 4,
  parameter int MAX_OBJECTS = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  zit_pkg::id_t        object_id,
  input  zit_pkg::coord_t     box_left,
  input  zit_pkg::coord_t     box_top,
  input  zit_pkg::coord_t     box_right,
  input  zit_pkg::coord_t     box_bottom,
  input  logic                cfg_write,
  input  zit_pkg::cfg_idx_t   cfg_index,
  input  zit_pkg::cfg_data_t  cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output zit_pkg::id_t        result_object_id,
  output zit_pkg::mask_t      entered_mask,
  output zit_pkg::mask_t      left_mask,
  output zit_pkg::mask_t      inside_mask
);
  import zit_pkg::*;

  localparam int ZONES  = (NUM_ZONES < MASK_W) ? NUM_ZONES : MASK_W;
  localparam int DEPTH  = (MAX_OBJECTS < (1 << ID_W)) ? MAX_OBJECTS : (1 << ID_W);
  localparam int SLOT_W = $clog2(DEPTH);
  localparam coord_t COORD_KEEP = coord_t'((32'd1 << COORD_BITS) - 32'd1);

  logic in_accept;
  logic s1_advance;

  mask_t     zone_en;
  rect_arr_t zone_rect;

  logic [SLOT_W-1:0] slot_lut [1 << ID_W];
  logic [SLOT_W-1:0] in_slot;
  rect_t             in_box;

  // stage 1
  logic              s1_valid;
  id_t               s1_id;
  logic [SLOT_W-1:0] s1_slot;
  rect_t             s1_box;
  logic              s1_entry_valid;
  logic              fwd_hit;
  logic [ZONES-1:0]  fwd_data;

  logic [DEPTH-1:0]  entry_valid;
  logic [ZONES-1:0]  rd_data;
  logic [ZONES-1:0]  old_bits;
  logic [ZONES-1:0]  inside_z;
  logic [ZONES-1:0]  en_z;
  logic [ZONES-1:0]  mem_next;
  mask_t             inside_all;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // id modulo MAX_OBJECTS as a constant lookup over all ids
  for (genvar i = 0; i < (1 << ID_W); i++) begin : g_slot_lut
    assign slot_lut[i] = SLOT_W'(i % DEPTH);
  end

  assign in_slot = slot_lut[object_id];
  assign in_box  = order_rect(box_left, box_top, box_right, box_bottom, COORD_KEEP);

  zit_zone_regs #(
    .ZONES      (ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_zone_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .zone_en   (zone_en),
    .zone_rect (zone_rect)
  );

  zit_ram #(
    .WIDTH (ZONES),
    .DEPTH (DEPTH)
  ) u_membership (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_slot),
    .wdata (mem_next),
    .re    (in_accept),
    .raddr (in_slot),
    .rdata (rd_data)
  );

  zit_overlap u_overlap (
    .box       (s1_box),
    .zone_rect (zone_rect),
    .zone_en   (zone_en),
    .hit       (inside_all)
  );

  assign old_bits = fwd_hit ? fwd_data : (s1_entry_valid ? rd_data : '0);
  assign inside_z = inside_all[ZONES-1:0];
  assign en_z     = zone_en[ZONES-1:0];
  assign mem_next = (old_bits & ~en_z) | inside_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        // entry being written this cycle: RAM read returns the old value
        fwd_hit  <= s1_advance && (s1_slot == in_slot);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        entry_valid[s1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_id          <= object_id;
      s1_slot        <= in_slot;
      s1_box         <= in_box;
      s1_entry_valid <= entry_valid[in_slot] || (s1_advance && (s1_slot == in_slot));
      fwd_data       <= mem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result_object_id <= s1_id;
      entered_mask     <= MASK_W'(inside_z & ~old_bits);
      left_mask        <= MASK_W'(~inside_z & old_bits & en_z);
      inside_mask      <= MASK_W'(inside_z);
    end
  end

  `ZIT_ASSERT_NOW(a_enter_left_disjoint, out_valid, (entered_mask & left_mask) == '0, "entered and left overlap")
  `ZIT_ASSERT_NOW(a_enter_in_inside, out_valid, (entered_mask & ~inside_mask) == '0, "entered zone not inside")
  `ZIT_ASSERT_NEXT(a_entry_marked, s1_advance, entry_valid[$past(s1_slot)], "written entry not marked valid")
  `ZIT_ASSERT_NEXT(a_result_follows, s1_advance, out_valid, "result register not loaded")

endmodule

/* hdl/zit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module zit_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/zit_zone_regs.sv */
// Zone configuration registers; corners are ordered and trimmed on write.
module zit_zone_regs #(
  parameter int ZONES      = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  zit_pkg::cfg_idx_t   cfg_index,
  input  zit_pkg::cfg_data_t  cfg_data,
  output zit_pkg::mask_t      zone_en,
  output zit_pkg::rect_arr_t  zone_rect
);
  import zit_pkg::*;

  localparam coord_t COORD_KEEP = coord_t'((32'd1 << COORD_BITS) - 32'd1);
  localparam mask_t  ZONE_MASK  = mask_t'((32'd1 << ZONES) - 32'd1);

  rect_t wr_rect;

  assign wr_rect = order_rect(cfg_data[15:0], cfg_data[31:16],
                              cfg_data[47:32], cfg_data[63:48], COORD_KEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_en   <= '0;
      zone_rect <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ZONE_ENABLE: zone_en <= cfg_data[MASK_W-1:0] & ZONE_MASK;
        REG_ZONE_RECT_0: if (ZONES > 0) zone_rect[0] <= wr_rect;
        REG_ZONE_RECT_1: if (ZONES > 1) zone_rect[1] <= wr_rect;
        REG_ZONE_RECT_2: if (ZONES > 2) zone_rect[2] <= wr_rect;
        REG_ZONE_RECT_3: if (ZONES > 3) zone_rect[3] <= wr_rect;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/zit_overlap.sv */
// Parallel box-versus-zone overlap test, one compare set per zone.
module zit_overlap (
  input  zit_pkg::rect_t      box,
  input  zit_pkg::rect_arr_t  zone_rect,
  input  zit_pkg::mask_t      zone_en,
  output zit_pkg::mask_t      hit
);
  import zit_pkg::*;

  always_comb begin
    for (int z = 0; z < MASK_W; z++) begin
      hit[z] = zone_en[z]
               && (box.x_lo <= zone_rect[z].x_hi) && (box.x_hi >= zone_rect[z].x_lo)
               && (box.y_lo <= zone_rect[z].y_hi) && (box.y_hi >= zone_rect[z].y_lo);
    end
  end

endmodule

/* verif/zit_checker.sv */
// Checker for the zone intrusion tracker: predicts zone events per request and compares results.
module zit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  zit_pkg::id_t       object_id,
  input  zit_pkg::coord_t    box_left,
  input  zit_pkg::coord_t    box_top,
  input  zit_pkg::coord_t    box_right,
  input  zit_pkg::coord_t    box_bottom,
  input  logic               cfg_write,
  input  zit_pkg::cfg_idx_t  cfg_index,
  input  zit_pkg::cfg_data_t cfg_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  zit_pkg::id_t       result_object_id,
  input  zit_pkg::mask_t     entered_mask,
  input  zit_pkg::mask_t     left_mask,
  input  zit_pkg::mask_t     inside_mask,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import zit_pkg::*;

  localparam int OBJECTS = 64;

  typedef struct packed {
    id_t   id;
    mask_t entered;
    mask_t departed;
    mask_t occupied;
  } zone_event_t;

  mask_t       zone_on;
  cfg_data_t   zone_rect [MASK_W];
  mask_t       membership [OBJECTS];
  zone_event_t expected_events [$];
  zone_event_t want;
  zone_event_t got;
  int          slot;

  // Corners may come in either order; bounds are inclusive on both sides.
  function automatic zone_event_t predict_zone_events(input id_t id, input coord_t l,
                                                      input coord_t t, input coord_t r,
                                                      input coord_t b, input mask_t prev);
    coord_t      bx_lo, bx_hi, by_lo, by_hi;
    coord_t      zx_lo, zx_hi, zy_lo, zy_hi;
    coord_t      c [4];
    mask_t       hit;
    zone_event_t ev;
    int          z, k;
    hit   = '0;
    bx_lo = (l < r) ? l : r;
    bx_hi = (l < r) ? r : l;
    by_lo = (t < b) ? t : b;
    by_hi = (t < b) ? b : t;
    for (z = 0; z < MASK_W; z++) begin
      for (k = 0; k < 4; k++) c[k] = zone_rect[z][COORD_W*k +: COORD_W];
      zx_lo = (c[0] < c[2]) ? c[0] : c[2];
      zx_hi = (c[0] < c[2]) ? c[2] : c[0];
      zy_lo = (c[1] < c[3]) ? c[1] : c[3];
      zy_hi = (c[1] < c[3]) ? c[3] : c[1];
      if (bx_lo <= zx_hi && bx_hi >= zx_lo && by_lo <= zy_hi && by_hi >= zy_lo) hit[z] = 1'b1;
    end
    hit         = hit & zone_on;
    ev.id       = id;
    ev.entered  = hit & ~prev;
    ev.departed = ~hit & prev & zone_on;
    ev.occupied = hit;
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      zone_on = '0;
      foreach (zone_rect[z]) zone_rect[z] = '0;
      foreach (membership[i]) membership[i] = '0;
      expected_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ZONE_ENABLE: zone_on = cfg_data[MASK_W-1:0];
          REG_ZONE_RECT_0: zone_rect[0] = cfg_data;
          REG_ZONE_RECT_1: zone_rect[1] = cfg_data;
          REG_ZONE_RECT_2: zone_rect[2] = cfg_data;
          REG_ZONE_RECT_3: zone_rect[3] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {result_object_id, entered_mask, left_mask, inside_mask};
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("zit_checker: result for object %0d with no request outstanding", got.id);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (want.id !== got.id || want.entered !== got.entered ||
              want.departed !== got.departed || want.occupied !== got.occupied) begin
            if (fail_count < 10)
              $display({"zit_checker: mismatch, expected id %0d entered %b left %b inside %b,",
                        " got id %0d entered %b left %b inside %b"},
                       want.id, want.entered, want.departed, want.occupied,
                       got.id, got.entered, got.departed, got.occupied);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        slot = int'(object_id) % OBJECTS;
        want = predict_zone_events(object_id, box_left, box_top, box_right, box_bottom,
                                   membership[slot]);
        // disabled zones keep their mark untouched
        membership[slot] = (membership[slot] & ~zone_on) | want.occupied;
        expected_events = {expected_events, want};
      end
    end
    pending = expected_events.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the zone intrusion tracker: stimulus, zone programming and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import zit_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  id_t       object_id = '0;
  coord_t    box_left = '0;
  coord_t    box_top = '0;
  coord_t    box_right = '0;
  coord_t    box_bottom = '0;
  logic      cfg_write = 1'b0;
  cfg_idx_t  cfg_index = REG_ZONE_ENABLE;
  cfg_data_t cfg_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  id_t       result_object_id;
  mask_t     entered_mask;
  mask_t     left_mask;
  mask_t     inside_mask;
  int        fail_count;
  int        pending;

  int        send_idle_pct = 15;
  int        recv_idle_pct = 85;
  int        hold_off_reqs = 0;
  int        hold_off_done = 0;
  int        stuck_cycles = 0;
  int        batch_items;
  cfg_data_t zone_rect_tb [MASK_W];

  zone_intrusion_tracker i_dut (.*);
  zit_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfg_data_t pack_rect(input coord_t x1, input coord_t y1,
                                          input coord_t x2, input coord_t y2);
    return {y2, x2, y1, x1};
  endfunction

  function automatic cfg_data_t random_rect();
    return {$urandom, $urandom};
  endfunction

  // Enable word carries random upper bits; spare also hits the indexes past the last zone.
  task automatic program_zones(input mask_t en, input cfg_data_t r0, input cfg_data_t r1,
                               input cfg_data_t r2, input cfg_data_t r3, input bit spare);
    cfg_data_t word;
    word = {$urandom, $urandom};
    word[MASK_W-1:0] = en;
    zone_rect_tb[0] = r0;
    zone_rect_tb[1] = r1;
    zone_rect_tb[2] = r2;
    zone_rect_tb[3] = r3;
    cfg_write <= 1'b1;
    cfg_index <= REG_ZONE_ENABLE;
    cfg_data  <= word;
    @(posedge clk);
    for (int z = 0; z < MASK_W; z++) begin
      cfg_index <= cfg_idx_t'(REG_ZONE_RECT_0 + z);
      cfg_data  <= zone_rect_tb[z];
      @(posedge clk);
    end
    if (spare) begin
      for (int k = 1; k <= 3; k++) begin
        cfg_index <= cfg_idx_t'(REG_ZONE_RECT_3 + k);
        cfg_data  <= random_rect();
        @(posedge clk);
      end
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_box(input id_t id, input coord_t l, input coord_t t,
                          input coord_t r, input coord_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    object_id  <= id;
    box_left   <= l;
    box_top    <= t;
    box_right  <= r;
    box_bottom <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly a few recurring objects moving around zone edges, so marks get set and cleared.
  task automatic send_tracked_box();
    id_t    id;
    coord_t l, t, r, b, tmp;
    int     z, kind;
    if ($urandom_range(9) < 7) id = id_t'($urandom_range(7) * 9);
    else id = id_t'($urandom);
    kind = $urandom_range(99);
    z = $urandom_range(MASK_W - 1);
    if (kind < 60) begin
      l = ($urandom_range(1) ? zone_rect_tb[z][15:0] : zone_rect_tb[z][47:32])
          + coord_t'($urandom_range(8)) - coord_t'(4);
      t = ($urandom_range(1) ? zone_rect_tb[z][31:16] : zone_rect_tb[z][63:48])
          + coord_t'($urandom_range(8)) - coord_t'(4);
      r = l + coord_t'($urandom_range(40));
      b = t + coord_t'($urandom_range(40));
    end else if (kind < 85) begin
      l = coord_t'($urandom);
      t = coord_t'($urandom);
      r = l + coord_t'($urandom_range(300));
      b = t + coord_t'($urandom_range(300));
    end else begin
      l = coord_t'($urandom);
      t = coord_t'($urandom);
      r = coord_t'($urandom);
      b = coord_t'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      tmp = l;
      l = r;
      r = tmp;
    end
    if ($urandom_range(3) == 0) begin
      tmp = t;
      t = b;
      b = tmp;
    end
    send_box(id, l, t, r, b);
  endtask

  // Settings change only with the pipeline empty.
  task automatic finish_batch();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_reqs != hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done++;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all zones disabled out of reset
    send_box(5, 0, 0, 16'hFFFF, 16'hFFFF);
    send_box(5, 0, 0, 0, 0);
    finish_batch();

    // normal zone, swapped-corner zone, pixel at origin, pixel at far corner
    program_zones(4'hF, pack_rect(100, 100, 200, 200), pack_rect(500, 600, 300, 400),
                  pack_rect(0, 0, 0, 0),
                  pack_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
    send_box(0, 150, 150, 160, 160);
    send_box(0, 150, 150, 160, 160);
    send_box(0, 200, 200, 300, 300);
    send_box(0, 201, 201, 299, 399);
    send_box(0, 301, 400, 299, 400);
    send_box(63, 16'hFFFF, 16'hFFFF, 0, 0);
    send_box(63, 0, 0, 0, 0);
    send_box(1, 16'hFFFF, 0, 16'hFFFF, 0);
    send_box(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_box(42, 500, 600, 500, 600);
    send_box(42, 501, 601, 700, 700);
    send_box(21, 99, 99, 99, 99);
    send_box(21, 201, 150, 250, 160);
    send_box(21, 0, 0, 16'hFFFF, 0);
    finish_batch();

    // zones 1 and 3 off: their marks must survive untouched
    program_zones(4'b0101, zone_rect_tb[0], zone_rect_tb[1], zone_rect_tb[2],
                  zone_rect_tb[3], 1'b0);
    send_box(63, 0, 0, 16'hFFFF, 16'hFFFF);
    send_box(0, 1000, 1000, 1000, 1000);
    send_box(1, 0, 0, 0, 0);
    finish_batch();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 85 : 0;
      recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 15 : 0;
      case (seg)
        1: program_zones(4'hF, pack_rect(0, 0, 16'hFFFF, 16'hFFFF), '0, '1,
                         pack_rect(16'hFFFF, 16'hFFFF, 0, 0), 1'b1);
        2: program_zones(mask_t'($urandom_range(1, 14)), random_rect(), random_rect(),
                         random_rect(), random_rect(), 1'b0);
        3: program_zones('0, random_rect(), random_rect(), random_rect(), random_rect(),
                         1'b0);
        4: program_zones(mask_t'($urandom), random_rect(), random_rect(), random_rect(),
                         random_rect(), 1'b0);
        default: program_zones(4'hF, random_rect(), random_rect(), random_rect(),
                               random_rect(), 1'b0);
      endcase
      batch_items = (seg == 3) ? 30 : 120;
      for (int n = 0; n < batch_items; n++) begin
        // receiver backs off for a while so the pipeline fills and stalls requests
        if (seg == 5 && (n == 10 || n == 70)) hold_off_reqs++;
        send_tracked_box();
      end
      finish_batch();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
